@@ rtl/core/q2r_pkg.sv @@
// Package for the quaternion to rotation matrix block: widths, types, constants.
// No dependencies.
`default_nettype none
package q2r_pkg;
    localparam int unsigned FRAC_BITS_DEF = 14;
    localparam int unsigned QW = 16;          // input component width
    localparam int unsigned MW = 16;          // matrix term width
    localparam int unsigned NW = 33;          // squared norm, at most 2^32
    localparam int unsigned TW = 35;          // signed term width
    localparam int unsigned NTERM = 9;

    typedef logic signed [TW-1:0] term_t;
    typedef logic [NW-1:0] norm_t;
endpackage
`default_nettype wire

@@ rtl/core/q2r_div.sv @@
// Pipelined restoring divider: one quotient bit per stage.
// Depends on q2r_pkg.
`default_nettype none
module q2r_div
    import q2r_pkg::*;
#(
    parameter int unsigned NUM_W = 34,
    parameter int unsigned DEN_W = 34,
    parameter int unsigned Q_W = 17
) (
    input  wire logic              aclk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    output logic      [Q_W-1:0]    quo
);
    // num < den * 2^Q_W is guaranteed by the caller
    localparam int unsigned RW = DEN_W + 1;
    logic [RW-1:0]    rem_reg [Q_W+1];
    logic [NUM_W-1:0] num_reg [Q_W+1];
    logic [DEN_W-1:0] den_reg [Q_W+1];
    logic [Q_W-1:0]   q_reg   [Q_W+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= '0;
            num_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
        end
    end

    for (genvar s = 0; s < Q_W; s++) begin : g_st
        localparam int unsigned BI = Q_W - 1 - s;
        logic [NUM_W:0] part;
        logic [RW:0]    trial;
        logic           take;
        logic [RW-1:0]  rem_next;
        always_comb begin
            // partial remainder with the next numerator bits folded in
            if (s == 0) begin
                part = {1'b0, num_reg[0] >> BI};
            end else begin
                part = {1'b0, ({{(NUM_W > RW ? NUM_W - RW : 0){1'b0}}, rem_reg[s]}
                        << 1) | NUM_W'((num_reg[s] >> BI) & NUM_W'(1))};
            end
            trial = (RW+1)'(part) - {2'b0, den_reg[s]};
            take  = ~trial[RW];
            rem_next = take ? trial[RW-1:0] : RW'(part);
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= rem_next;
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= q_reg[s] | (Q_W'(take) << BI);
            end
        end
    end
    assign quo = q_reg[Q_W];
endmodule
`default_nettype wire

@@ rtl/core/quaternion_to_rotation_matrix.sv @@
// Top level: quaternion to normalized 3x3 rotation matrix, streaming.
// Depends on q2r_pkg and q2r_div.
//
//  channel | ports              | beat contents
//  --------+--------------------+------------------------------------------
//  in      | s_axis_t*          | tdata: w,x,y,z (16b each, w lowest)
//  out     | m_axis_t*          | tdata: m00..m22 (16b each); tuser: degenerate
//
// One beat per cycle while the output is not stalled. Stages in order: products,
// term sums, numerator scaling, then one quotient bit per stage of the
// nine parallel dividers. Whole pipeline advances when the output is free
// or empty; valid bits travel with data, so stalls lose nothing.
// aresetn clears only valid bits.
`default_nettype none
module quaternion_to_rotation_matrix
    import q2r_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire logic [63:0]    s_axis_tdata,   // w, x, y, z
    output logic                m_axis_tvalid,
    input  wire logic           m_axis_tready,
    output logic [143:0]        m_axis_tdata,   // m00,m01,m02,m10,m11,m12,m20,m21,m22
    output logic [0:0]          m_axis_tuser    // degenerate
);
    localparam int unsigned QBITS = FRAC_BITS + 2;     // quotient bits (mag <= 2^FRAC_BITS)
    localparam int unsigned NUMW  = TW + FRAC_BITS + 1;
    localparam int unsigned DENW  = NW + 1;
    localparam int unsigned DLAT  = QBITS + 1;
    localparam int unsigned LAT   = 3 + DLAT;
    localparam int unsigned CW    = QBITS + MW;        // room for the saturation limits

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end
    assign m_axis_tvalid = vld_reg[LAT-1];

    // stage 1: ten products
    logic signed [31:0] pr_reg [10];
    logic signed [QW-1:0] w, x, y, z;
    assign w = s_axis_tdata[15:0];
    assign x = s_axis_tdata[31:16];
    assign y = s_axis_tdata[47:32];
    assign z = s_axis_tdata[63:48];
    always_ff @(posedge aclk) begin
        if (en) begin
            pr_reg[0] <= w * w; pr_reg[1] <= x * x;
            pr_reg[2] <= y * y; pr_reg[3] <= z * z;
            pr_reg[4] <= x * y; pr_reg[5] <= w * z;
            pr_reg[6] <= x * z; pr_reg[7] <= w * y;
            pr_reg[8] <= y * z; pr_reg[9] <= w * x;
        end
    end

    // stage 2: terms and norm
    term_t t_reg [NTERM];
    norm_t n_reg;
    function automatic term_t sx(input logic signed [31:0] v);
        sx = TW'(v);
    endfunction
    always_ff @(posedge aclk) begin
        if (en) begin
            t_reg[0] <= sx(pr_reg[0]) + sx(pr_reg[1]) - sx(pr_reg[2]) - sx(pr_reg[3]);
            t_reg[1] <= (sx(pr_reg[4]) - sx(pr_reg[5])) <<< 1;
            t_reg[2] <= (sx(pr_reg[6]) + sx(pr_reg[7])) <<< 1;
            t_reg[3] <= (sx(pr_reg[4]) + sx(pr_reg[5])) <<< 1;
            t_reg[4] <= sx(pr_reg[0]) - sx(pr_reg[1]) + sx(pr_reg[2]) - sx(pr_reg[3]);
            t_reg[5] <= (sx(pr_reg[8]) - sx(pr_reg[9])) <<< 1;
            t_reg[6] <= (sx(pr_reg[6]) - sx(pr_reg[7])) <<< 1;
            t_reg[7] <= (sx(pr_reg[8]) + sx(pr_reg[9])) <<< 1;
            t_reg[8] <= sx(pr_reg[0]) - sx(pr_reg[1]) - sx(pr_reg[2]) + sx(pr_reg[3]);
            n_reg <= NW'(32'(pr_reg[0])) + NW'(32'(pr_reg[1]))
                   + NW'(32'(pr_reg[2])) + NW'(32'(pr_reg[3]));
        end
    end

    // stage 3: magnitude * 2^(F+1) + n, denominator 2n
    logic [NUMW-1:0] num_reg [NTERM];
    logic [DENW-1:0] den_reg;
    logic [NTERM-1:0] neg_reg;
    logic             zero_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NTERM; i++) begin
                num_reg[i] <= (NUMW'(t_reg[i][TW-1] ? -t_reg[i] : t_reg[i]) << (FRAC_BITS + 1))
                            + NUMW'(n_reg);
                neg_reg[i] <= t_reg[i][TW-1];
            end
            den_reg  <= {n_reg, 1'b0};
            zero_reg <= (n_reg == '0);
        end
    end

    // sign and zero flag ride alongside the dividers
    logic [NTERM-1:0] negd_reg [DLAT];
    logic             zd_reg   [DLAT];
    always_ff @(posedge aclk) begin
        if (en) begin
            negd_reg[0] <= neg_reg;
            zd_reg[0]   <= zero_reg;
            for (int i = 1; i < DLAT; i++) begin
                negd_reg[i] <= negd_reg[i-1];
                zd_reg[i]   <= zd_reg[i-1];
            end
        end
    end

    for (genvar i = 0; i < NTERM; i++) begin : g_div
        logic [QBITS-1:0] q;
        logic signed [MW-1:0] r;
        q2r_div #(.NUM_W(NUMW), .DEN_W(DENW), .Q_W(QBITS)) u_div (
            .aclk (aclk), .en (en),
            .num  (num_reg[i]), .den (den_reg), .quo (q)
        );
        always_comb begin
            if (zd_reg[DLAT-1]) begin
                r = '0;
            end else if (negd_reg[DLAT-1][i]) begin
                r = (CW'(q) > CW'(32768)) ? -16'sd32768 : MW'(-$signed({1'b0, q}));
            end else begin
                r = (CW'(q) > CW'(32767)) ? 16'sd32767 : MW'(q);
            end
        end
        assign m_axis_tdata[i*MW +: MW] = r;
    end
    assign m_axis_tuser = zd_reg[DLAT-1];

`ifndef SYNTHESIS
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == '0)
        else $error("degenerate with nonzero matrix");
`endif
endmodule
`default_nettype wire

@@ sim/q2r_checker.sv @@
// Checker for quaternion_to_rotation_matrix: watches both stream channels,
// predicts each matrix from the accepted quaternion and compares. Uses q2r_pkg.
`timescale 1ns / 100ps
module q2r_checker
    import q2r_pkg::*;
#(
    parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_axis_tvalid,
    input  wire logic         s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,
    input  wire logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic [143:0] m_axis_tdata,
    input  wire logic [0:0]   m_axis_tuser,
    output int                fail_count,
    output int                pending_count
);
    typedef struct packed {
        logic [143:0] terms;
        logic         degenerate;
    } rot_matrix_t;

    rot_matrix_t matrix_queue[$];

    // term * 2^FRAC_BITS / norm, rounded half away from zero, saturated
    function automatic logic [15:0] norm_scale(longint t, longint unsigned norm);
        longint unsigned mag;
        longint unsigned q;
        mag = (t < 0) ? longint'(-t) : longint'(t);
        q = ((mag << (FRAC_BITS + 1)) + norm) / (2 * norm);
        if (t < 0)
            return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
        return (q > 32767) ? 16'h7fff : 16'(q);
    endfunction

    function automatic rot_matrix_t rotation_of(logic [63:0] quat);
        longint w, x, y, z, ww, xx, yy, zz;
        longint unsigned norm;
        longint raw[9];
        rot_matrix_t res;
        w = longint'($signed(quat[15:0]));
        x = longint'($signed(quat[31:16]));
        y = longint'($signed(quat[47:32]));
        z = longint'($signed(quat[63:48]));
        ww = w * w; xx = x * x; yy = y * y; zz = z * z;
        norm = ww + xx + yy + zz;
        res = '0;
        if (norm == 0) begin
            res.degenerate = 1'b1;
            return res;
        end
        raw[0] = ww + xx - yy - zz;
        raw[1] = 2 * (x * y - w * z);
        raw[2] = 2 * (x * z + w * y);
        raw[3] = 2 * (x * y + w * z);
        raw[4] = ww - xx + yy - zz;
        raw[5] = 2 * (y * z - w * x);
        raw[6] = 2 * (x * z - w * y);
        raw[7] = 2 * (y * z + w * x);
        raw[8] = ww - xx - yy + zz;
        for (int i = 0; i < 9; i++)
            res.terms[16*i +: 16] = norm_scale(raw[i], norm);
        return res;
    endfunction

    assign pending_count = matrix_queue.size();

    initial fail_count = 0;

    always @(posedge aclk) begin
        rot_matrix_t want;
        if (aresetn && s_axis_tvalid && s_axis_tready)
            matrix_queue.push_back(rotation_of(s_axis_tdata));
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (matrix_queue.size() == 0) begin
                $error("unexpected matrix beat");
                fail_count++;
            end else begin
                want = matrix_queue.pop_front();
                for (int i = 0; i < 9; i++)
                    if (m_axis_tdata[16*i +: 16] !== want.terms[16*i +: 16]) begin
                        $error("m%0d%0d expected %0d actual %0d", i / 3, i % 3,
                               $signed(want.terms[16*i +: 16]),
                               $signed(m_axis_tdata[16*i +: 16]));
                        fail_count++;
                    end
                if (m_axis_tuser[0] !== want.degenerate) begin
                    $error("degenerate expected %0b actual %0b",
                           want.degenerate, m_axis_tuser[0]);
                    fail_count++;
                end
            end
        end
    end
endmodule

@@ sim/testbench.sv @@
// Testbench top for quaternion_to_rotation_matrix: clock, reset, quaternion
// stimulus and output back-pressure. Depends on q2r_pkg and q2r_checker.
`timescale 1ns / 100ps
module testbench;
    import q2r_pkg::*;

    localparam int LATENCY     = FRAC_BITS_DEF + 6;
    localparam int CYCLE_LIMIT = 400000;

    logic         aclk;
    logic         aresetn;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [63:0]  s_axis_tdata;   // w, x, y, z from the low bits
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // m00..m22 from the low bits
    logic [0:0]   m_axis_tuser;   // degenerate
    int           fail_count;
    int           pending_count;
    int           cycle_count;

    // idle and stall percentages of the current phase
    int send_idle_pct;
    int recv_stall_pct;
    // long hold-off on the receiver
    bit hold_req;
    int hold_left;

    quaternion_to_rotation_matrix u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    q2r_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // watchdog
    initial cycle_count = 0;
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        m_axis_tready = 1'b0;
        hold_left = 0;
    end
    always @(posedge aclk) begin
        if (hold_req && hold_left == 0)
            hold_left <= 300;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        if (hold_left > 1 || (hold_req && hold_left == 0))
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // one beat offered; waits for acceptance, random gaps before it
    task automatic send_quat(logic [15:0] w, logic [15:0] x,
                             logic [15:0] y, logic [15:0] z);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_random_quat();
        logic [15:0] c[4];
        int shape;
        shape = $urandom_range(9);
        for (int i = 0; i < 4; i++) begin
            case (shape)
                0: c[i] = ($urandom_range(1)) ? 16'h8000 : 16'h7fff;
                1: c[i] = $urandom_range(1) ? 16'($urandom_range(3)) : 16'h0;
                2: c[i] = 16'(int'($urandom_range(32)) - 16);
                default: c[i] = 16'($urandom);
            endcase
        end
        // shape 3: one random component forced to 16384, the others stay random
        if (shape == 3) c[$urandom_range(3)] = 16'd16384;
        send_quat(c[0], c[1], c[2], c[3]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    initial begin
        aresetn        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero, unit axes, extremes, half and mixed signs
        send_quat(16'h0, 16'h0, 16'h0, 16'h0);
        send_quat(16'd16384, 16'h0, 16'h0, 16'h0);
        send_quat(16'h0, 16'd16384, 16'h0, 16'h0);
        send_quat(16'h0, 16'h0, 16'd16384, 16'h0);
        send_quat(16'h0, 16'h0, 16'h0, 16'd16384);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h0001, 16'h0, 16'h0, 16'h0);
        send_quat(16'hffff, 16'h0, 16'h0, 16'h0);
        send_quat(16'h0001, 16'h0001, 16'h0001, 16'h0001);
        send_quat(16'hffff, 16'h0001, 16'hffff, 16'h0001);
        send_quat(16'h0001, 16'h0001, 16'h0, 16'h0);
        send_quat(16'h0, 16'h0001, 16'h0002, 16'h0003);
        send_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_quat(16'h0, 16'h0, 16'h0, 16'h8000);
        send_quat(16'h2d41, 16'h2d41, 16'h0, 16'h0);
        drain();

        // random phases: none, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = (phase == 1) ? 70 : (phase == 3) ? 38 : 0;
            recv_stall_pct = (phase == 2) ? 70 : (phase == 3) ? 38 : 0;
            for (int n = 0; n < 300; n++) begin
                // long hold-off while the sender keeps offering
                if (phase == 0 && n == 50) hold_req <= 1'b1;
                if (phase == 0 && n == 51) hold_req <= 1'b0;
                // sender pause until everything is back
                if (n == 150) drain();
                send_random_quat();
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

@@ files.f @@
rtl/core/q2r_pkg.sv
rtl/core/q2r_div.sv
rtl/core/quaternion_to_rotation_matrix.sv
sim/q2r_checker.sv
sim/testbench.sv
